### rtl/core/dltq_pkg.sv
// Package: shared types and constants for the delta-list timer queue.
package dltq_pkg;

  localparam int MAX_TIMERS   = 16;
  localparam int TICK_WIDTH   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int IDX_W        = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W        = $clog2(MAX_TIMERS + 1);
  localparam int K_W          = $clog2(RESULT_LIMIT + 1);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SCHED  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_REINSERT = 2'd3;

  localparam logic [1:0] SOP_NOP    = 2'd0;
  localparam logic [1:0] SOP_WDELTA = 2'd1;
  localparam logic [1:0] SOP_INSERT = 2'd2;
  localparam logic [1:0] SOP_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] delay_ticks;
    logic [15:0] event_id;
    logic [15:0] wake_value;
    logic [15:0] reload_ticks;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] fired_event;
    logic [15:0] fired_value;
    logic [1:0]  status;
    logic [4:0]  removed_count;
    logic [31:0] tick_now;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [TICK_WIDTH-1:0] delta;
    logic [15:0]           event_id;
    logic [15:0]           value;
    logic [TICK_WIDTH-1:0] reload;
  } entry_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      pos;
    logic                  split;
    logic [TICK_WIDTH-1:0] split_delta;
    entry_t                wentry;
  } store_cmd_t;

endpackage

### rtl/core/delta_list_timer_queue.sv
// Delta-list timer queue: sequencer around a shared adder and the entry list.
// A schedule or cancel first walks the list removing entries with its event id; a schedule
// then walks it again to insert the new entry. A tick decrements the head delta, then fires
// each due head entry in turn and re-inserts reloading ones with an insert walk.
// Results strobe in the cycle after the step that produces them.
// Throughput: one transaction at a time; busy is high until the last result is produced
// (zero-delay and unknown commands answer at once and never raise it).
// Reset (rst, synchronous) empties the list and clears the tick counter.
// The receiver cannot stall: each result is valid for exactly one cycle on done.
module delta_list_timer_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dltq_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output dltq_pkg::result_t result
);
  import dltq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TICK_DEC = 3'd1;
  localparam logic [2:0] S_FIRE     = 3'd2;
  localparam logic [2:0] S_CANCEL   = 3'd3;
  localparam logic [2:0] S_INS_CMP  = 3'd4;
  localparam logic [2:0] S_INS_SUB  = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [31:0]      tick_counter, tick_counter_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [1:0]       op, op_next;          // command being worked
  entry_t           ins, ins_next;        // entry being inserted, delta = remaining
  logic [TICK_WIDTH-1:0] carry, carry_next; // folded delta of removed entries
  logic [4:0]       removed, removed_next;
  logic [K_W-1:0]   k, k_next;            // expiries captured this tick
  logic             pend, pend_next;      // expiry waiting for its last flag
  logic [15:0]      pend_ev, pend_ev_next, pend_val, pend_val_next;
  logic [1:0]       pend_st, pend_st_next;
  logic             ins_tick, ins_tick_next; // insert is a reload re-insert

  logic             emit;
  result_t          emit_res;

  store_cmd_t       scmd;
  entry_t           rd, head;
  logic [TICK_WIDTH-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [TICK_WIDTH:0]   alu_sum;

  logic             due;

  dltq_store u_store (.clk(clk), .scmd(scmd), .rd(rd), .head(head));
  dltq_alu   u_alu   (.a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum));

  assign busy = (state != S_IDLE);

  // head fires when it sits at zero and the burst limit is not reached
  assign due = (entry_count != '0) && (head.delta == '0) && (k < K_W'(RESULT_LIMIT));

  always_comb begin
    state_next        = state;
    entry_count_next  = entry_count;
    tick_counter_next = tick_counter;
    pos_next          = pos;
    op_next           = op;
    ins_next          = ins;
    carry_next        = carry;
    removed_next      = removed;
    k_next            = k;
    pend_next         = pend;
    pend_ev_next      = pend_ev;
    pend_val_next     = pend_val;
    pend_st_next      = pend_st;
    ins_tick_next     = ins_tick;
    emit              = 1'b0;
    emit_res          = '0;
    emit_res.tick_now = tick_counter;
    emit_res.last_result = 1'b1;
    scmd              = '0;
    scmd.op           = SOP_NOP;
    scmd.pos          = pos[IDX_W-1:0];
    scmd.wentry       = ins;
    alu_a             = rd.delta;
    alu_b             = ins.delta;
    alu_sub           = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next      = item.cmd;
          pos_next     = '0;
          carry_next   = '0;
          removed_next = '0;
          k_next       = '0;
          pend_next    = 1'b0;
          ins_tick_next = 1'b0;
          ins_next.delta    = item.delay_ticks[TICK_WIDTH-1:0];
          ins_next.event_id = item.event_id;
          ins_next.value    = item.wake_value;
          ins_next.reload   = item.reload_ticks[TICK_WIDTH-1:0];
          priority if (item.cmd == CMD_TICK) begin
            tick_counter_next = tick_counter + 32'd1;
            state_next = S_TICK_DEC;
          end else if (item.cmd == CMD_SCHED && item.delay_ticks == '0) begin
            emit = 1'b1;
            emit_res.result_kind = KIND_STATUS;
            emit_res.status      = ST_ZERO;
          end else if (item.cmd == CMD_SCHED || item.cmd == CMD_CANCEL) begin
            state_next = S_CANCEL;
          end else begin
            emit = 1'b1;
            emit_res.result_kind = KIND_STATUS;
            emit_res.status      = ST_OK;
          end
        end
      end

      S_TICK_DEC: begin
        emit_res.tick_now = tick_counter;
        if (entry_count == '0) begin
          emit = 1'b1;
          emit_res.result_kind = KIND_IDLE;
          state_next = S_IDLE;
        end else begin
          scmd.pos = '0;
          alu_a    = head.delta;
          alu_b    = TICK_WIDTH'(1);
          if (head.delta != '0) begin
            scmd.op = SOP_WDELTA;
            scmd.wentry.delta = alu_sum[TICK_WIDTH-1:0];
          end
          state_next = S_FIRE;
        end
      end

      S_FIRE: begin
        if (pend) begin
          emit = 1'b1;
          emit_res.result_kind = KIND_EXPIRY;
          emit_res.fired_event = pend_ev;
          emit_res.fired_value = pend_val;
          emit_res.status      = pend_st;
          emit_res.last_result = !due;
          pend_next = 1'b0;
        end else if (!due && k == '0) begin
          emit = 1'b1;
          emit_res.result_kind = KIND_IDLE;
        end
        if (due) begin
          scmd.op  = SOP_REMOVE;
          scmd.pos = '0;
          entry_count_next = entry_count - CNT_W'(1);
          k_next        = k + K_W'(1);
          pend_next     = 1'b1;
          pend_ev_next  = head.event_id;
          pend_val_next = head.value;
          pend_st_next  = ST_OK;
          if (head.reload != '0) begin
            ins_next      = head;
            ins_next.delta = head.reload;
            ins_tick_next = 1'b1;
            pos_next      = '0;
            state_next    = S_INS_CMP;
          end
        end else begin
          state_next = S_IDLE;
        end
      end

      S_CANCEL: begin
        alu_a   = carry;
        alu_b   = rd.delta;
        alu_sub = 1'b0;
        if (pos < entry_count) begin
          if (rd.event_id == ins.event_id) begin
            scmd.op = SOP_REMOVE;
            entry_count_next = entry_count - CNT_W'(1);
            removed_next = removed + 5'd1;
            carry_next   = alu_sum[TICK_WIDTH-1:0];
          end else begin
            scmd.op = SOP_WDELTA;
            scmd.wentry.delta = alu_sum[TICK_WIDTH-1:0];
            carry_next = '0;
            pos_next   = pos + CNT_W'(1);
          end
        end else if (op == CMD_CANCEL) begin
          emit = 1'b1;
          emit_res.result_kind   = KIND_STATUS;
          emit_res.status        = ST_OK;
          emit_res.removed_count = removed;
          state_next = S_IDLE;
        end else if (entry_count >= CNT_W'(MAX_TIMERS)) begin
          emit = 1'b1;
          emit_res.result_kind   = KIND_STATUS;
          emit_res.status        = ST_FULL;
          emit_res.removed_count = removed;
          state_next = S_IDLE;
        end else begin
          pos_next   = '0;
          state_next = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        // rd.delta - remaining: no borrow and nonzero means the new entry lands here
        if (entry_count >= CNT_W'(MAX_TIMERS)) begin
          pend_st_next = ST_REINSERT;
          state_next   = S_FIRE;
        end else if (pos == entry_count ||
                     (!alu_sum[TICK_WIDTH] && alu_sum[TICK_WIDTH-1:0] != '0)) begin
          scmd.op          = SOP_INSERT;
          scmd.split       = (pos != entry_count);
          scmd.split_delta = alu_sum[TICK_WIDTH-1:0];
          entry_count_next = entry_count + CNT_W'(1);
          if (ins_tick) begin
            state_next = S_FIRE;
          end else begin
            emit = 1'b1;
            emit_res.result_kind   = KIND_STATUS;
            emit_res.status        = ST_OK;
            emit_res.removed_count = removed;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_INS_SUB;
        end
      end

      S_INS_SUB: begin
        alu_a = ins.delta;
        alu_b = rd.delta;
        ins_next.delta = alu_sum[TICK_WIDTH-1:0];
        pos_next   = pos + CNT_W'(1);
        state_next = S_INS_CMP;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      tick_counter <= '0;
      done         <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      tick_counter <= tick_counter_next;
      done         <= emit;
      pend         <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    op       <= op_next;
    ins      <= ins_next;
    carry    <= carry_next;
    removed  <= removed_next;
    k        <= k_next;
    pend_ev  <= pend_ev_next;
    pend_val <= pend_val_next;
    pend_st  <= pend_st_next;
    ins_tick <= ins_tick_next;
    if (emit) result <= emit_res;
  end

  // list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_TIMERS))
    else $error("entry count over capacity");

  // an expiry that is not the last one keeps the block busy for the rest
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_result) |-> busy)
    else $error("non-final result while idle");

  // tick counter moves only on an accepted tick transaction
  a_tick_stable: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy && item.cmd == CMD_TICK) |=> $stable(tick_counter))
    else $error("tick counter moved without a tick");

  // zero-delay schedule answers in the next cycle
  a_zero_delay: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_SCHED && item.delay_ticks == 16'd0)
      |=> (done && result.status == ST_ZERO))
    else $error("zero delay schedule not rejected");

endmodule

### rtl/core/dltq_alu.sv
// Shared add/subtract unit used by the tick-decrement, cancel and insert steps of the sequencer.
module dltq_alu (
  input  logic [dltq_pkg::TICK_WIDTH-1:0] a,
  input  logic [dltq_pkg::TICK_WIDTH-1:0] b,
  input  logic                            sub,
  output logic [dltq_pkg::TICK_WIDTH:0]   sum
);
  import dltq_pkg::*;

  // bit TICK_WIDTH is the borrow on subtract
  assign sum = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

### rtl/core/dltq_store.sv
// Entry list storage with shift-up insert and shift-down remove.
module dltq_store (
  input  logic                 clk,
  input  dltq_pkg::store_cmd_t scmd,
  output dltq_pkg::entry_t     rd,
  output dltq_pkg::entry_t     head
);
  import dltq_pkg::*;

  entry_t ent [MAX_TIMERS];

  assign rd   = ent[scmd.pos];
  assign head = ent[0];

  always_ff @(posedge clk) begin
    unique case (scmd.op)
      SOP_WDELTA: begin
        ent[scmd.pos].delta <= scmd.wentry.delta;
      end
      SOP_INSERT: begin
        for (int j = 1; j < MAX_TIMERS; j++) begin
          if (IDX_W'(j) > scmd.pos) begin
            // entry pushed out of the insert slot keeps the split delta
            if (scmd.split && (IDX_W'(j - 1) == scmd.pos))
              ent[j] <= {scmd.split_delta, ent[j-1].event_id, ent[j-1].value,
                         ent[j-1].reload};
            else
              ent[j] <= ent[j-1];
          end
        end
        ent[scmd.pos] <= scmd.wentry;
      end
      SOP_REMOVE: begin
        for (int j = 0; j < MAX_TIMERS - 1; j++) begin
          if (IDX_W'(j) >= scmd.pos) ent[j] <= ent[j+1];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
